FILE: sv/drs_pkg.sv
`default_nettype none
package drs_pkg;

	// set size and derived index widths
	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// value and digit widths
	localparam int VAL_W   = 31;
	localparam int RADIX   = 10;
	localparam int DIGIT_W = $clog2(RADIX);

	// reciprocal of ten: floor(q / 10) == (q * RECIP) >> RECIP_SHIFT for any q below 2^32
	localparam int          RECIP_W     = 32;
	localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             final_item;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0] sorted_value;
		logic             last_out;
	} result_t;

	// one stored entry: the value, its quotient by the current power of ten, its digit
	typedef struct packed {
		logic [VAL_W-1:0]   value;
		logic [VAL_W-1:0]   quot;
		logic [DIGIT_W-1:0] digit;
	} entry_t;

endpackage
`default_nettype wire

FILE: sv/drs_digit_unit.sv
`default_nettype none
module drs_digit_unit (
	input  wire                          clk,
	input  wire  [drs_pkg::VAL_W-1:0]    num,
	output logic [drs_pkg::VAL_W-1:0]    quot,
	output logic [drs_pkg::DIGIT_W-1:0]  digit
);
	import drs_pkg::*;

	localparam int PROD_W = VAL_W + RECIP_W;

	logic [PROD_W-1:0] prod_s1;
	logic [VAL_W-1:0]  num_s1;
	logic [VAL_W-1:0]  tenx;
	logic [VAL_W-1:0]  rem;

	// multiply by the reciprocal of ten, register the product
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(num) * PROD_W'(RECIP);
		num_s1  <= num;
	end

	// quotient from the product, remainder by one shift-add and subtract
	always_comb begin
		quot  = VAL_W'(prod_s1 >> RECIP_SHIFT);
		tenx  = (quot << 3) + (quot << 1);
		rem   = num_s1 - tenx;
		digit = rem[DIGIT_W-1:0];
	end

endmodule
`default_nettype wire

FILE: sv/decimal_radix_sorter.sv
`default_nettype none
// Base-10 LSD radix sorter for sets of up to DEPTH non-negative 31-bit values.
// Input channel item/item_valid/item_stall: one value per word, one cycle per
// word while loading. A word with final_item set closes the set; words beyond
// DEPTH are dropped but a dropped final word still starts the sort.
// After the final word the block stalls its input and sorts. It runs one pass
// per decimal digit of the largest value (none if that value is zero). Each
// pass splits every held value into digit and quotient through the single
// reciprocal multiplier, forms the bucket offsets, scatters the values into
// the bucket memory and copies them back; each memory has one read and one
// write port. Output channel result/result_valid/result_stall then carries
// the held values in ascending order, one at a time from the value store,
// last_out on the last.
// A stall on the output holds the registered word and pauses the readout; the
// input reopens as soon as the last word is loaded into the output register.
// Reset (arst_n low) empties the set and drops any word in flight.
module decimal_radix_sorter (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_valid,
	output logic                    item_stall,
	input  wire  drs_pkg::item_t    item,
	output logic                    result_valid,
	input  wire                     result_stall,
	output drs_pkg::result_t        result
);
	import drs_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_START   = 4'd1;
	localparam logic [3:0] S_CNT_RD  = 4'd2;
	localparam logic [3:0] S_CNT_MUL = 4'd3;
	localparam logic [3:0] S_CNT_ACC = 4'd4;
	localparam logic [3:0] S_PRE     = 4'd5;
	localparam logic [3:0] S_DST_RD  = 4'd6;
	localparam logic [3:0] S_DST_WR  = 4'd7;
	localparam logic [3:0] S_CPY_RD  = 4'd8;
	localparam logic [3:0] S_CPY_WR  = 4'd9;
	localparam logic [3:0] S_MAX_MUL = 4'd10;
	localparam logic [3:0] S_MAX_UPD = 4'd11;
	localparam logic [3:0] S_OUT_RD  = 4'd12;
	localparam logic [3:0] S_OUT_WR  = 4'd13;

	logic [3:0]         state_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   count_q;
	logic [VAL_W-1:0]   max_q;
	logic [CNT_W-1:0]   cnt_q   [RADIX];
	logic [CNT_W-1:0]   start_q [RADIX];
	logic [DIGIT_W-1:0] pre_d_q;
	logic [CNT_W-1:0]   acc_q;
	logic               out_valid_q;
	result_t            out_q;

	entry_t             val_mem [DEPTH];
	entry_t             bkt_mem [DEPTH];
	entry_t             val_rd_q;
	entry_t             bkt_rd_q;

	logic               take;
	logic               store;
	logic               idx_last;
	logic [CNT_W-1:0]   idx_nxt;
	logic               out_free;
	logic               val_we;
	logic [ADDR_W-1:0]  val_wa;
	entry_t             val_wd;
	logic [VAL_W-1:0]   unit_num;
	logic [VAL_W-1:0]   unit_quot;
	logic [DIGIT_W-1:0] unit_digit;

	assign take     = item_valid && !item_stall;
	assign store    = take && (count_q < CNT_W'(DEPTH));
	assign idx_nxt  = idx_q + 1'b1;
	assign idx_last = (idx_nxt == count_q);
	assign out_free = !out_valid_q || !result_stall;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// shared divide-by-ten unit: stored quotients while counting, the maximum between passes
	assign unit_num = (state_q == S_MAX_MUL) ? max_q : val_rd_q.quot;

	drs_digit_unit u_digit (
		.clk   (clk),
		.num   (unit_num),
		.quot  (unit_quot),
		.digit (unit_digit)
	);

	// value store write port
	always_comb begin
		val_we = 1'b0;
		val_wa = idx_q[ADDR_W-1:0];
		val_wd = bkt_rd_q;
		case (state_q)
			S_IDLE: begin
				val_we = store;
				val_wa = count_q[ADDR_W-1:0];
				val_wd = '{value: item.value, quot: item.value, digit: '0};
			end
			S_CNT_ACC: begin
				val_we = 1'b1;
				val_wd = '{value: val_rd_q.value, quot: unit_quot, digit: unit_digit};
			end
			S_CPY_WR: begin
				val_we = 1'b1;
			end
			default: begin
				val_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (val_we)
			val_mem[val_wa] <= val_wd;
		val_rd_q <= val_mem[idx_q[ADDR_W-1:0]];
	end

	// bucket store: scatter at the bucket's next slot, read back in order
	always_ff @(posedge clk) begin
		if (state_q == S_DST_WR)
			bkt_mem[start_q[val_rd_q.digit][ADDR_W-1:0]] <= val_rd_q;
		bkt_rd_q <= bkt_mem[idx_q[ADDR_W-1:0]];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			max_q       <= '0;
			pre_d_q     <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			for (int d = 0; d < RADIX; d++) begin
				cnt_q[d]   <= '0;
				start_q[d] <= '0;
			end
		end else begin
			// drop the output word once taken, unless the readout reloads it
			if (out_valid_q && !result_stall && state_q != S_OUT_WR)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (store) begin
						count_q <= count_q + 1'b1;
						if (item.value > max_q)
							max_q <= item.value;
					end
					if (take && item.final_item)
						state_q <= S_START;
				end
				S_START: begin
					idx_q <= '0;
					if (max_q == '0) begin
						state_q <= S_OUT_RD;
					end else begin
						for (int d = 0; d < RADIX; d++)
							cnt_q[d] <= '0;
						state_q <= S_CNT_RD;
					end
				end
				S_CNT_RD: begin
					state_q <= S_CNT_MUL;
				end
				S_CNT_MUL: begin
					state_q <= S_CNT_ACC;
				end
				S_CNT_ACC: begin
					cnt_q[unit_digit] <= cnt_q[unit_digit] + 1'b1;
					if (idx_last) begin
						idx_q   <= '0;
						pre_d_q <= '0;
						acc_q   <= '0;
						state_q <= S_PRE;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_CNT_RD;
					end
				end
				S_PRE: begin
					start_q[pre_d_q] <= acc_q;
					acc_q            <= acc_q + cnt_q[pre_d_q];
					pre_d_q          <= pre_d_q + 1'b1;
					if (pre_d_q == DIGIT_W'(RADIX - 1))
						state_q <= S_DST_RD;
				end
				S_DST_RD: begin
					state_q <= S_DST_WR;
				end
				S_DST_WR: begin
					start_q[val_rd_q.digit] <= start_q[val_rd_q.digit] + 1'b1;
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= S_CPY_RD;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_DST_RD;
					end
				end
				S_CPY_RD: begin
					state_q <= S_CPY_WR;
				end
				S_CPY_WR: begin
					if (idx_last) begin
						idx_q   <= '0;
						state_q <= S_MAX_MUL;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_CPY_RD;
					end
				end
				S_MAX_MUL: begin
					state_q <= S_MAX_UPD;
				end
				S_MAX_UPD: begin
					max_q   <= unit_quot;
					state_q <= S_START;
				end
				S_OUT_RD: begin
					state_q <= S_OUT_WR;
				end
				S_OUT_WR: begin
					// wait for a free output slot, then advance
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (idx_last) begin
							idx_q   <= '0;
							count_q <= '0;
							max_q   <= '0;
							for (int d = 0; d < RADIX; d++)
								cnt_q[d] <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_nxt;
							state_q <= S_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (state_q == S_OUT_WR && out_free) begin
			out_q.sorted_value <= val_rd_q.value;
			out_q.last_out     <= idx_last;
		end
	end

	// a closing word always locks the input for the sort
	a_final_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.final_item |=> item_stall)
		else $error("input not stalled after closing word");

	// the held count never passes the store depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("held count beyond store depth");

	// every scatter lands inside the held set
	a_scatter_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DST_WR |-> start_q[val_rd_q.digit] < count_q)
		else $error("bucket slot outside held set");

	// a word that ends a run leaves the block ready for the next set
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && out_q.last_out |-> !item_stall && count_q == '0)
		else $error("block not emptied after last word");

endmodule
`default_nettype wire
